// File: rtl/core/hsv_color_distance_segmenter_defines.svh
// ----------------------------------------------------------------------------
// HSV segmenter assertion macros
// Concurrent checks on the local clk and rst_n of the module that uses them.
// ----------------------------------------------------------------------------
`ifndef HSV_COLOR_DISTANCE_SEGMENTER_DEFINES_SVH
`define HSV_COLOR_DISTANCE_SEGMENTER_DEFINES_SVH

// Same-cycle implication
`define HCDS_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication
`define HCDS_ASSERT_NXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: rtl/core/hcds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV segmenter package
// Field widths, register indexes, codes and shared types.
// ----------------------------------------------------------------------------
package hcds_pkg;

    localparam int HUE_BITS      = 8;
    localparam int CH_BITS       = 8;
    localparam int DIST_BITS     = 9;
    localparam int RAD_BITS      = 18;
    localparam int CUTOFF_BITS   = 16;
    localparam int MIN_BITS      = 22;
    localparam int DEV_BITS      = 9;
    localparam int PREC_BITS     = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 22;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [HUE_BITS-1:0] HUE_CIRCLE = 8'd180;
    localparam logic [DEV_BITS-1:0] DEV_RESET  = 9'd511;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_HUE = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_SAT = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_VAL = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_BLOB   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_DEV_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_PRECISION  = 3'd5;

    // commands and result kinds
    localparam logic CMD_HIST     = 1'b0;
    localparam logic CMD_CLASSIFY = 1'b1;
    localparam logic KIND_CUTOFF  = 1'b0;
    localparam logic KIND_MASK    = 1'b1;

    typedef struct packed {
        logic [HUE_BITS-1:0]    target_hue;
        logic [CH_BITS-1:0]     target_saturation;
        logic [CH_BITS-1:0]     target_value;
        logic [MIN_BITS-1:0]    min_blob_pixels;
        logic [DEV_BITS-1:0]    deviation_limit;
        logic [PREC_BITS-1:0]   precision_q8_8;
    } hcds_cfg_t;

    typedef struct packed {
        logic                   command;
        logic                   last_pixel;
        logic [DIST_BITS-1:0]   distance;
    } hcds_job_t;

endpackage

// File: rtl/core/hcds_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV segmenter channels
// Pixel input, result output and register write channels.
// ----------------------------------------------------------------------------
interface hcds_pix_if
    import hcds_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                command;
    logic [HUE_BITS-1:0] pixel_hue;
    logic [CH_BITS-1:0]  pixel_saturation;
    logic [CH_BITS-1:0]  pixel_value;
    logic                last_pixel;

    modport source (output valid, command, pixel_hue, pixel_saturation, pixel_value,
                    last_pixel, input ready);
    modport sink   (input valid, command, pixel_hue, pixel_saturation, pixel_value,
                    last_pixel, output ready);
endinterface

interface hcds_res_if
    import hcds_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic                   result_kind;
    logic                   mask_bit;
    logic [CUTOFF_BITS-1:0] cutoff;

    modport source (output valid, result_kind, mask_bit, cutoff, input ready);
    modport sink   (input valid, result_kind, mask_bit, cutoff, output ready);
endinterface

interface hcds_cfg_if
    import hcds_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/hsv_color_distance_segmenter.sv
`timescale 1ns / 1ps
// Mask path: difference, squares, 9-step square root, queue, registered mask result.
// A new pixel is taken only once the front end has pushed the last one's job.
// End of histogram pass: bin triple search, report, then a bin-by-bin clear.
// Reset: asynchronous, active low; a full histogram clear runs before the first pixel
// is taken, register writes are taken throughout.
// ----------------------------------------------------------------------------
// HSV color distance segmenter
// Two-pass color distance histogram, cutoff search and per-pixel mask.
// ----------------------------------------------------------------------------
module hsv_color_distance_segmenter
    import hcds_pkg::*;
#(
    parameter int HIST_BINS  = 512,
    parameter int COUNT_BITS = 22
) (
    input  logic       clk,
    input  logic       rst_n,
    hcds_pix_if.sink   pixels,
    hcds_res_if.source results,
    hcds_cfg_if.sink   cfg
);

    hcds_cfg_t cfg_reg;
    logic      init_done;
    logic      push_valid, push_ready, pop_valid, pop_ready;
    hcds_job_t push_job, pop_job;

    assign cfg.ready = 1'b1;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{target_hue:        '0,
                         target_saturation: '0,
                         target_value:      '0,
                         min_blob_pixels:   '0,
                         deviation_limit:   DEV_RESET,
                         precision_q8_8:    '0};
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_TARGET_HUE: cfg_reg.target_hue        <= cfg.data[HUE_BITS-1:0];
                REG_TARGET_SAT: cfg_reg.target_saturation <= cfg.data[CH_BITS-1:0];
                REG_TARGET_VAL: cfg_reg.target_value      <= cfg.data[CH_BITS-1:0];
                REG_MIN_BLOB:   cfg_reg.min_blob_pixels   <= cfg.data[MIN_BITS-1:0];
                REG_DEV_LIMIT:  cfg_reg.deviation_limit   <= cfg.data[DEV_BITS-1:0];
                REG_PRECISION:  cfg_reg.precision_q8_8    <= cfg.data[PREC_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    hcds_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pixels),
        .enable    (init_done),
        .cfg_q     (cfg_reg),
        .job_valid (push_valid),
        .job_ready (push_ready),
        .job       (push_job)
    );

    hcds_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    hcds_back #(
        .HIST_BINS  (HIST_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_q     (cfg_reg),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job       (pop_job),
        .results   (results),
        .init_done (init_done)
    );

endmodule

// File: rtl/core/hcds_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV segmenter RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module hcds_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/hcds_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV segmenter front end
// Takes a pixel, forms the weighted difference and its integer square root.
// ----------------------------------------------------------------------------
module hcds_front
    import hcds_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    hcds_pix_if.sink   pixels,
    input  logic       enable,
    input  hcds_cfg_t  cfg_q,
    output logic       job_valid,
    input  logic       job_ready,
    output hcds_job_t  job
);

    localparam int REM_BITS = 11;

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_DIFF = 3'd1;
    localparam logic [2:0] F_SQ   = 3'd2;
    localparam logic [2:0] F_ROOT = 3'd3;
    localparam logic [2:0] F_PUSH = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [3:0]           cnt_reg, cnt_next;
    logic                 cmd_reg, cmd_next;
    logic                 last_reg, last_next;
    logic [HUE_BITS-1:0]  h_reg, h_next;
    logic [CH_BITS-1:0]   s_reg, s_next;
    logic [CH_BITS-1:0]   v_reg, v_next;
    logic [CH_BITS-1:0]   dh_reg, dh_next;
    logic [CH_BITS-1:0]   ds_reg, ds_next;
    logic [CH_BITS-1:0]   dv_reg, dv_next;
    logic [RAD_BITS-1:0]  rad_reg, rad_next;
    logic [REM_BITS-1:0]  rem_reg, rem_next;
    logic [DIST_BITS-1:0] root_reg, root_next;

    logic [HUE_BITS-1:0]    h_r, th_r, dh_a, dh_w;
    logic [REM_BITS+1:0]    shifted, trial;

    assign pixels.ready = enable && (state_reg == F_IDLE);
    assign job_valid    = (state_reg == F_PUSH);
    assign job.command    = cmd_reg;
    assign job.last_pixel = last_reg;
    assign job.distance   = root_reg;

    // hue difference on the circle, taken the short way
    always_comb
    begin
        h_r  = (h_reg >= HUE_CIRCLE) ? h_reg - HUE_CIRCLE : h_reg;
        th_r = (cfg_q.target_hue >= HUE_CIRCLE) ? cfg_q.target_hue - HUE_CIRCLE
                                                : cfg_q.target_hue;
        dh_a = (h_r > th_r) ? h_r - th_r : th_r - h_r;
        dh_w = ((HUE_CIRCLE - dh_a) < dh_a) ? HUE_CIRCLE - dh_a : dh_a;
    end

    // one root bit per step
    assign shifted = {rem_reg, rad_reg[RAD_BITS-1 -: 2]};
    assign trial   = {2'b00, root_reg, 2'b01};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd_next   = cmd_reg;
        last_next  = last_reg;
        h_next     = h_reg;
        s_next     = s_reg;
        v_next     = v_reg;
        dh_next    = dh_reg;
        ds_next    = ds_reg;
        dv_next    = dv_reg;
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (pixels.valid && pixels.ready)
                begin
                    cmd_next   = pixels.command;
                    last_next  = pixels.last_pixel;
                    h_next     = pixels.pixel_hue;
                    s_next     = pixels.pixel_saturation;
                    v_next     = pixels.pixel_value;
                    state_next = F_DIFF;
                end
            end
            F_DIFF:
            begin
                dh_next    = {dh_w[CH_BITS-2:0], 1'b0};
                ds_next    = (s_reg > cfg_q.target_saturation) ?
                             s_reg - cfg_q.target_saturation : cfg_q.target_saturation - s_reg;
                dv_next    = (v_reg > cfg_q.target_value) ?
                             v_reg - cfg_q.target_value : cfg_q.target_value - v_reg;
                state_next = F_SQ;
            end
            F_SQ:
            begin
                rad_next   = RAD_BITS'(dh_reg) * RAD_BITS'(dh_reg)
                           + RAD_BITS'(ds_reg) * RAD_BITS'(ds_reg)
                           + RAD_BITS'(dv_reg) * RAD_BITS'(dv_reg);
                rem_next   = '0;
                root_next  = '0;
                cnt_next   = '0;
                state_next = F_ROOT;
            end
            F_ROOT:
            begin
                if (shifted >= trial)
                begin
                    rem_next  = REM_BITS'(shifted - trial);
                    root_next = {root_reg[DIST_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = REM_BITS'(shifted);
                    root_next = {root_reg[DIST_BITS-2:0], 1'b0};
                end
                rad_next = {rad_reg[RAD_BITS-3:0], 2'b00};
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'(DIST_BITS - 1))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (job_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        last_reg <= last_next;
        h_reg    <= h_next;
        s_reg    <= s_next;
        v_reg    <= v_next;
        dh_reg   <= dh_next;
        ds_reg   <= ds_next;
        dv_reg   <= dv_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

endmodule

// File: rtl/core/hcds_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV segmenter job queue
// Two-entry FIFO between the distance front end and the back end.
// ----------------------------------------------------------------------------
module hcds_queue
    import hcds_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  hcds_job_t push_job,
    output logic      pop_valid,
    input  logic      pop_ready,
    output hcds_job_t pop_job
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    hcds_job_t           slot_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wptr_reg, rptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic                do_push, do_pop;

    assign push_ready = (count_reg != CNT_BITS'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = slot_reg[rptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= (wptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= (rptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= push_job;
        end
    end

endmodule

// File: rtl/core/hcds_back.sv
`timescale 1ns / 1ps
`include "hsv_color_distance_segmenter_defines.svh"
// ----------------------------------------------------------------------------
// HSV segmenter back end
// Histogram update, cutoff search, histogram clear and mask output.
// ----------------------------------------------------------------------------
module hcds_back
    import hcds_pkg::*;
#(
    parameter int HIST_BINS  = 512,
    parameter int COUNT_BITS = 22
) (
    input  logic       clk,
    input  logic       rst_n,
    input  hcds_cfg_t  cfg_q,
    input  logic       job_valid,
    output logic       job_ready,
    input  hcds_job_t  job,
    hcds_res_if.source results,
    output logic       init_done
);

    localparam int BIN_BITS  = $clog2(HIST_BINS);
    localparam int IDX_BITS  = BIN_BITS + 1;
    localparam int TRI_BITS  = COUNT_BITS + 2;
    localparam int TOT_BITS  = COUNT_BITS + BIN_BITS + 1;
    localparam int CMP_BITS  = (TOT_BITS > MIN_BITS) ? TOT_BITS : MIN_BITS;
    localparam int PROD_BITS = IDX_BITS + PREC_BITS;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [IDX_BITS-1:0]   BINS_X    = IDX_BITS'(HIST_BINS);
    localparam logic [BIN_BITS-1:0]   LAST_BIN  = BIN_BITS'(HIST_BINS - 1);

    localparam logic [3:0] B_CLEAR   = 4'd0;
    localparam logic [3:0] B_IDLE    = 4'd1;
    localparam logic [3:0] B_RMW     = 4'd2;
    localparam logic [3:0] B_S_START = 4'd3;
    localparam logic [3:0] B_S_READ  = 4'd4;
    localparam logic [3:0] B_S_ADD   = 4'd5;
    localparam logic [3:0] B_S_EVAL  = 4'd6;
    localparam logic [3:0] B_S_CUT   = 4'd7;
    localparam logic [3:0] B_REPORT  = 4'd8;

    logic [3:0]             state_reg, state_next;
    logic                   init_reg, init_next;
    logic [BIN_BITS-1:0]    clr_reg, clr_next;
    logic [BIN_BITS-1:0]    smallest_reg, smallest_next;
    logic [CUTOFF_BITS-1:0] cutoff_reg, cutoff_next;
    logic                   last_reg, last_next;
    logic [BIN_BITS-1:0]    bin_reg, bin_next;
    logic [IDX_BITS-1:0]    i_reg, i_next;
    logic [1:0]             k_reg, k_next;
    logic                   inrange_reg, inrange_next;
    logic [TRI_BITS-1:0]    cur_reg, cur_next;
    logic [TRI_BITS-1:0]    prev_reg, prev_next;
    logic [TOT_BITS-1:0]    total_reg, total_next;
    logic [PROD_BITS-1:0]   prod_reg, prod_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_kind_reg, out_kind_next;
    logic                   out_mask_reg, out_mask_next;
    logic [CUTOFF_BITS-1:0] out_cut_reg, out_cut_next;

    logic                   ram_we;
    logic [BIN_BITS-1:0]    ram_waddr, ram_raddr;
    logic [COUNT_BITS-1:0]  ram_wdata, ram_rdata;

    logic                   out_free, pop;
    logic [IDX_BITS-1:0]    dist_x, smallest_x, dev_x, addr_x, i_step;
    logic [TOT_BITS-1:0]    tot_sum;
    logic [PROD_BITS-1:0]   cut_sum;

    hcds_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (HIST_BINS)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free   = !out_valid_reg || results.ready;
    assign job_ready  = (state_reg == B_IDLE) && init_reg
                     && (job.command == CMD_HIST || out_free);
    assign pop        = job_valid && job_ready;
    assign init_done  = init_reg;

    assign results.valid       = out_valid_reg;
    assign results.result_kind = out_kind_reg;
    assign results.mask_bit    = out_mask_reg;
    assign results.cutoff      = out_cut_reg;

    assign dist_x     = IDX_BITS'(job.distance);
    assign smallest_x = IDX_BITS'(smallest_reg);
    assign dev_x      = IDX_BITS'(cfg_q.deviation_limit);
    assign addr_x     = i_reg + IDX_BITS'(k_reg);
    assign i_step     = i_reg + IDX_BITS'(3);
    assign tot_sum    = total_reg + TOT_BITS'(cur_reg);
    assign cut_sum    = PROD_BITS'(i_reg) + (prod_reg >> 8);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        init_next      = init_reg;
        clr_next       = clr_reg;
        smallest_next  = smallest_reg;
        cutoff_next    = cutoff_reg;
        last_next      = last_reg;
        bin_next       = bin_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        inrange_next   = inrange_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        total_next     = total_reg;
        prod_next      = prod_reg;
        out_kind_next  = out_kind_reg;
        out_mask_next  = out_mask_reg;
        out_cut_next   = out_cut_reg;
        out_valid_next = out_valid_reg && !results.ready;
        ram_we         = 1'b0;
        ram_waddr      = bin_reg;
        ram_wdata      = '0;
        ram_raddr      = addr_x[BIN_BITS-1:0];
        unique case (state_reg)
            B_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LAST_BIN)
                begin
                    clr_next      = '0;
                    init_next     = 1'b1;
                    smallest_next = LAST_BIN;
                    state_next    = B_IDLE;
                end
            end
            B_IDLE:
            begin
                ram_raddr = BIN_BITS'(job.distance);
                if (pop && job.command == CMD_CLASSIFY)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_MASK;
                    out_mask_next  = CUTOFF_BITS'(job.distance) < cutoff_reg;
                    out_cut_next   = cutoff_reg;
                end
                else if (pop)
                begin
                    last_next = job.last_pixel;
                    bin_next  = BIN_BITS'(job.distance);
                    if (dist_x < smallest_x)
                    begin
                        smallest_next = BIN_BITS'(job.distance);
                    end
                    if (dist_x < BINS_X)
                    begin
                        state_next = B_RMW;
                    end
                    else if (job.last_pixel)
                    begin
                        state_next = B_S_START;
                    end
                end
            end
            B_RMW:
            begin
                // saturating bin increment
                ram_we     = 1'b1;
                ram_wdata  = (ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + 1'b1;
                state_next = last_reg ? B_S_START : B_IDLE;
            end
            B_S_START:
            begin
                i_next     = smallest_x;
                k_next     = '0;
                cur_next   = '0;
                prev_next  = '0;
                total_next = '0;
                if (smallest_x < BINS_X && smallest_x < dev_x)
                begin
                    state_next = B_S_READ;
                end
                else
                begin
                    cutoff_next = '0;
                    state_next  = B_REPORT;
                end
            end
            B_S_READ:
            begin
                inrange_next = addr_x < BINS_X;
                state_next   = B_S_ADD;
            end
            B_S_ADD:
            begin
                cur_next = cur_reg + (inrange_reg ? TRI_BITS'(ram_rdata) : '0);
                if (k_reg == 2'd2)
                begin
                    state_next = B_S_EVAL;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = B_S_READ;
                end
            end
            B_S_EVAL:
            begin
                total_next = tot_sum;
                if (cur_reg < prev_reg
                    && CMP_BITS'(tot_sum) > CMP_BITS'(cfg_q.min_blob_pixels))
                begin
                    prod_next  = PROD_BITS'(i_reg - smallest_x)
                               * PROD_BITS'(cfg_q.precision_q8_8);
                    state_next = B_S_CUT;
                end
                else
                begin
                    prev_next = cur_reg;
                    cur_next  = '0;
                    k_next    = '0;
                    i_next    = i_step;
                    if (i_step < BINS_X && i_step < dev_x)
                    begin
                        state_next = B_S_READ;
                    end
                    else
                    begin
                        cutoff_next = '0;
                        state_next  = B_REPORT;
                    end
                end
            end
            B_S_CUT:
            begin
                cutoff_next = (cut_sum > PROD_BITS'({CUTOFF_BITS{1'b1}})) ?
                              {CUTOFF_BITS{1'b1}} : cut_sum[CUTOFF_BITS-1:0];
                state_next  = B_REPORT;
            end
            B_REPORT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_CUTOFF;
                    out_mask_next  = 1'b0;
                    out_cut_next   = cutoff_reg;
                    state_next     = B_CLEAR;
                end
            end
            default:
            begin
                state_next = B_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            init_reg      <= 1'b0;
            clr_reg       <= '0;
            smallest_reg  <= LAST_BIN;
            cutoff_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            clr_reg       <= clr_next;
            smallest_reg  <= smallest_next;
            cutoff_reg    <= cutoff_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg     <= last_next;
        bin_reg      <= bin_next;
        i_reg        <= i_next;
        k_reg        <= k_next;
        inrange_reg  <= inrange_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        total_reg    <= total_next;
        prod_reg     <= prod_next;
        out_kind_reg <= out_kind_next;
        out_mask_reg <= out_mask_next;
        out_cut_reg  <= out_cut_next;
    end

    // checks
    `HCDS_ASSERT_IMP(a_no_write_in_search,
        state_reg == B_S_READ || state_reg == B_S_ADD || state_reg == B_S_EVAL,
        !ram_we, "histogram written during search")
    `HCDS_ASSERT_NXT(a_mask_lands,
        pop && job.command == CMD_CLASSIFY,
        results.valid && out_kind_reg == KIND_MASK, "mask result not loaded")
    `HCDS_ASSERT_NXT(a_report_then_clear,
        state_reg == B_REPORT && out_free,
        state_reg == B_CLEAR && results.valid && out_kind_reg == KIND_CUTOFF,
        "report not followed by clear")

endmodule
